### rtl/sobov_pkg.sv
package sobov_pkg;

  localparam int PIX_W    = 8;
  localparam int POS_W    = 12;
  localparam int DIM_W    = 13;
  localparam int THR_W    = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IX_W = 2;
  localparam int SUM_W    = 10;
  localparam int GRAD_W   = 11;
  localparam int MAG_W    = 10;
  localparam int MSQ_W    = 20;
  localparam int SSQ_W    = 21;
  localparam int RAD_W    = 16;
  localparam int ROOT_W   = 8;
  localparam int THSQ_W   = 32;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;
  localparam logic [DIM_W-1:0] DIM_MIN = 13'd3;

  localparam logic [DIM_W-1:0] WIDTH_RST     = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST    = 13'd480;
  localparam logic [THR_W-1:0] THRESHOLD_RST = 16'd1600;

  typedef enum logic [CFG_IX_W-1:0] {
    CFG_IMAGE_WIDTH    = 2'd0,
    CFG_IMAGE_HEIGHT   = 2'd1,
    CFG_THRESHOLD      = 2'd2,
    CFG_OVERLAY_ENABLE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [POS_W-1:0] cx;
    logic [POS_W-1:0] cy;
    logic             last;
  } tag_t;

  typedef struct packed {
    logic                     valid;
    tag_t                     tag;
    logic signed [GRAD_W-1:0] sx;
    logic signed [GRAD_W-1:0] sy;
  } grad_t;

  typedef struct packed {
    logic             valid;
    tag_t             tag;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [SSQ_W-1:0] ssq;
  } sumsq_t;

  typedef struct packed {
    logic              valid;
    tag_t              tag;
    logic [PIX_W-1:0]  red;
    logic [PIX_W-1:0]  green;
    logic              mark;
    logic              big;
    logic [RAD_W-1:0]  rad;
    logic [ROOT_W-1:0] root;
  } root_t;

endpackage

### rtl/sobel_edge_rgb_overlay.sv
// An accepted word passes the stage 1 register, the gradient and sum-of-squares registers,
// the square-root stages and the output register, all stalling while out_ready is low and
// out_valid high. One pixel per cycle unless stalled; the line store is read at acceptance
// and written back as stage 1 advances, forwarding when consecutive pixels share a column.
// Border pixels produce no result word. Reset (rst_n low, synchronous) clears position,
// window and pipeline valids and loads the register defaults; line store contents are kept.
module sobel_edge_rgb_overlay #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sobov_pkg::PIX_W-1:0]    in_pixel,
  input  logic                           in_frame_start,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sobov_pkg::PIX_W-1:0]    out_red,
  output logic [sobov_pkg::PIX_W-1:0]    out_green,
  output logic [sobov_pkg::PIX_W-1:0]    out_blue,
  output logic [sobov_pkg::POS_W-1:0]    out_centre_x,
  output logic [sobov_pkg::POS_W-1:0]    out_centre_y,
  output logic                           out_last_of_frame,
  input  logic                           cfg_wr_en,
  input  logic [sobov_pkg::CFG_IX_W-1:0] cfg_index,
  input  logic [sobov_pkg::CFG_W-1:0]    cfg_data
);
  import sobov_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = AW + 1;
  localparam int RA = $clog2(MAX_HEIGHT);
  localparam int HW = RA + 1;
  localparam int NSTG = ROOT_W;

  logic [DIM_W-1:0]  width_cfg_r;
  logic [DIM_W-1:0]  height_cfg_r;
  logic [THR_W-1:0]  thr_r;
  logic              ovl_r;
  logic [THSQ_W-1:0] thr_sq_r;

  logic [31:0]       wid32;
  logic [31:0]       hgt32;
  logic [WW-1:0]     width;
  logic [HW-1:0]     height;

  logic              adv;
  logic              acc;

  logic [AW-1:0]     col_r;
  logic [RA-1:0]     row_r;
  logic [AW-1:0]     c0;
  logic [RA-1:0]     r0;
  logic [WW-1:0]     c_inc;
  logic [HW-1:0]     r_inc;
  logic [AW-1:0]     col_nxt;
  logic [RA-1:0]     row_nxt;
  logic              emit;
  tag_t              tag;

  logic [2*PIX_W-1:0] lstore [MAX_WIDTH];
  logic [2*PIX_W-1:0] mem_q_r;
  logic               fwd_r;
  logic [2*PIX_W-1:0] fwd_data_r;
  logic               fwd_nxt;

  logic              s1_valid_r;
  logic [PIX_W-1:0]  s1_px_r;
  logic [AW-1:0]     s1_col_r;
  logic              s1_emit_r;
  tag_t              s1_tag_r;
  logic [PIX_W-1:0]  s1_top;
  logic [PIX_W-1:0]  s1_mid;
  logic              s1_wr;

  logic [PIX_W-1:0]  win_r [3][3];
  logic [SUM_W-1:0]  gx_pos;
  logic [SUM_W-1:0]  gx_neg;
  logic [SUM_W-1:0]  gy_pos;
  logic [SUM_W-1:0]  gy_neg;

  grad_t             p2_r;
  grad_t             p2_nxt;
  sumsq_t            p3_r;
  sumsq_t            p3_nxt;
  logic [MAG_W-1:0]  ax;
  logic [MAG_W-1:0]  ay;
  logic [MSQ_W-1:0]  ax_sq;
  logic [MSQ_W-1:0]  ay_sq;

  root_t             rt_r   [NSTG];
  root_t             rt_in  [NSTG];
  root_t             rt_nxt [NSTG];
  logic [ROOT_W-1:0] trial  [NSTG];
  logic [RAD_W-1:0]  trial_sq [NSTG];

  logic              out_valid_r;
  logic [PIX_W-1:0]  out_red_r;
  logic [PIX_W-1:0]  out_green_r;
  logic [PIX_W-1:0]  out_blue_r;
  tag_t              out_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= WIDTH_RST;
      height_cfg_r <= HEIGHT_RST;
      thr_r        <= THRESHOLD_RST;
      ovl_r        <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:    width_cfg_r  <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:   height_cfg_r <= cfg_data[DIM_W-1:0];
        CFG_THRESHOLD:      thr_r        <= cfg_data[THR_W-1:0];
        CFG_OVERLAY_ENABLE: ovl_r        <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    thr_sq_r <= THSQ_W'(thr_r) * THSQ_W'(thr_r);
  end

  always_comb begin
    wid32 = 32'(width_cfg_r);
    if (width_cfg_r < DIM_MIN) begin
      wid32 = 32'(DIM_MIN);
    end else if (wid32 > 32'(MAX_WIDTH)) begin
      wid32 = 32'(MAX_WIDTH);
    end
    hgt32 = 32'(height_cfg_r);
    if (height_cfg_r < DIM_MIN) begin
      hgt32 = 32'(DIM_MIN);
    end else if (hgt32 > 32'(MAX_HEIGHT)) begin
      hgt32 = 32'(MAX_HEIGHT);
    end
    width  = WW'(wid32);
    height = HW'(hgt32);
  end

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign acc      = in_valid && in_ready;

  always_comb begin
    c0    = in_frame_start ? '0 : col_r;
    r0    = in_frame_start ? '0 : row_r;
    c_inc = {1'b0, c0} + WW'(1);
    r_inc = {1'b0, r0} + HW'(1);
    col_nxt = AW'(c_inc);
    row_nxt = r0;
    if (c_inc >= width) begin
      col_nxt = '0;
      row_nxt = (r_inc >= height) ? '0 : RA'(r_inc);
    end
    emit = (c0 >= AW'(2)) && (r0 >= RA'(2)) &&
           ({1'b0, c0} < width) && ({1'b0, r0} < height);
    tag.cx   = POS_W'(32'(c0) - 32'd1);
    tag.cy   = POS_W'(32'(r0) - 32'd1);
    tag.last = ({1'b0, c0} == width - WW'(1)) && ({1'b0, r0} == height - HW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign s1_top  = fwd_r ? fwd_data_r[2*PIX_W-1:PIX_W] : mem_q_r[2*PIX_W-1:PIX_W];
  assign s1_mid  = fwd_r ? fwd_data_r[PIX_W-1:0]       : mem_q_r[PIX_W-1:0];
  assign s1_wr   = adv && s1_valid_r;
  assign fwd_nxt = s1_valid_r && (c0 == s1_col_r);

  always_ff @(posedge clk) begin
    if (acc) begin
      mem_q_r <= lstore[c0];
    end
    if (s1_wr) begin
      lstore[s1_col_r] <= {s1_mid, s1_px_r};
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      fwd_r      <= fwd_nxt;
      fwd_data_r <= {s1_mid, s1_px_r};
      s1_px_r    <= in_pixel;
      s1_col_r   <= c0;
      s1_emit_r  <= emit;
      s1_tag_r   <= tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          win_r[j][i] <= '0;
        end
      end
    end else if (s1_wr) begin
      for (int j = 0; j < 3; j++) begin
        win_r[j][0] <= win_r[j][1];
        win_r[j][1] <= win_r[j][2];
      end
      win_r[0][2] <= s1_top;
      win_r[1][2] <= s1_mid;
      win_r[2][2] <= s1_px_r;
    end
  end

  always_comb begin
    gx_pos = SUM_W'(s1_top) + SUM_W'({s1_mid, 1'b0}) + SUM_W'(s1_px_r);
    gx_neg = SUM_W'(win_r[0][1]) + SUM_W'({win_r[1][1], 1'b0}) + SUM_W'(win_r[2][1]);
    gy_pos = SUM_W'(win_r[2][1]) + SUM_W'({win_r[2][2], 1'b0}) + SUM_W'(s1_px_r);
    gy_neg = SUM_W'(win_r[0][1]) + SUM_W'({win_r[0][2], 1'b0}) + SUM_W'(s1_top);
    p2_nxt.valid = s1_valid_r && s1_emit_r;
    p2_nxt.tag   = s1_tag_r;
    p2_nxt.sx    = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
    p2_nxt.sy    = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
  end

  always_comb begin
    ax    = MAG_W'(p2_r.sx < 0 ? -p2_r.sx : p2_r.sx);
    ay    = MAG_W'(p2_r.sy < 0 ? -p2_r.sy : p2_r.sy);
    ax_sq = ax * ax;
    ay_sq = ay * ay;
    p3_nxt.valid = p2_r.valid;
    p3_nxt.tag   = p2_r.tag;
    p3_nxt.red   = (ax > MAG_W'(PIX_MAX)) ? PIX_MAX : ax[PIX_W-1:0];
    p3_nxt.green = (ay > MAG_W'(PIX_MAX)) ? PIX_MAX : ay[PIX_W-1:0];
    p3_nxt.ssq   = {1'b0, ax_sq} + {1'b0, ay_sq};
  end

  always_comb begin
    rt_in[0].valid = p3_r.valid;
    rt_in[0].tag   = p3_r.tag;
    rt_in[0].red   = p3_r.red;
    rt_in[0].green = p3_r.green;
    rt_in[0].mark  = ovl_r && (THSQ_W'({p3_r.ssq, 8'd0}) > thr_sq_r);
    rt_in[0].big   = (p3_r.ssq[SSQ_W-1:RAD_W] != '0);
    rt_in[0].rad   = p3_r.ssq[RAD_W-1:0];
    rt_in[0].root  = '0;
    for (int i = 1; i < NSTG; i++) begin
      rt_in[i] = rt_r[i-1];
    end
    for (int i = 0; i < NSTG; i++) begin
      trial[i]    = rt_in[i].root | ROOT_W'(8'h80 >> i);
      trial_sq[i] = RAD_W'(trial[i]) * RAD_W'(trial[i]);
      rt_nxt[i]   = rt_in[i];
      if (trial_sq[i] <= rt_in[i].rad) begin
        rt_nxt[i].root = trial[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_r.valid <= 1'b0;
      p3_r.valid <= 1'b0;
      for (int i = 0; i < NSTG; i++) begin
        rt_r[i].valid <= 1'b0;
      end
    end else if (adv) begin
      p2_r <= p2_nxt;
      p3_r <= p3_nxt;
      for (int i = 0; i < NSTG; i++) begin
        rt_r[i] <= rt_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= rt_r[NSTG-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tag_r <= rt_r[NSTG-1].tag;
      if (rt_r[NSTG-1].mark) begin
        out_red_r   <= PIX_MAX;
        out_green_r <= '0;
        out_blue_r  <= '0;
      end else begin
        out_red_r   <= rt_r[NSTG-1].red;
        out_green_r <= rt_r[NSTG-1].green;
        out_blue_r  <= rt_r[NSTG-1].big ? PIX_MAX : rt_r[NSTG-1].root;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_red           = out_red_r;
  assign out_green         = out_green_r;
  assign out_blue          = out_blue_r;
  assign out_centre_x      = out_tag_r.cx;
  assign out_centre_y      = out_tag_r.cy;
  assign out_last_of_frame = out_tag_r.last;

endmodule
